// ===== sv/lrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear range map package
// Widths, register indexes, the pipeline stage record and the divider step
// shared by the linear range map unit.
// ----------------------------------------------------------------------------
package lrm_pkg;

    // Field and register widths.
    localparam int READING_W = 32;
    localparam int MAP_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Divider organization: quotient bits resolved per stage and stage count.
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = READING_W / DIV_BITS_PER_STAGE;

    // Stage roles inside the pipeline array.
    localparam int STG_OFFSET    = 0;
    localparam int STG_PRODUCT   = 1;
    localparam int STG_MAGNITUDE = 2;
    localparam int STG_DIV_FIRST = 3;
    localparam int PIPE_STAGES   = STG_DIV_FIRST + DIV_STAGES;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] SOURCE_LOW_RST  = 16'd0;
    localparam logic [CFG_W-1:0] SOURCE_HIGH_RST = 16'd1;
    localparam logic [CFG_W-1:0] TARGET_LOW_RST  = 16'd0;
    localparam logic [CFG_W-1:0] TARGET_HIGH_RST = 16'd1;

    // One pipeline stage. The word holds the offset, then the product, then
    // the dividend whose low bits fill with quotient bits as division runs.
    typedef struct packed {
        logic [READING_W-1:0] word;
        logic [CFG_W-1:0]     rem;
        logic                 neg;
    } stage_t;

    // Several restoring division steps on the dividend word and the partial
    // remainder. The remainder stays below the divisor magnitude when that is nonzero.
    function automatic stage_t div_stage(input stage_t cur, input logic [CFG_W-1:0] dmag);
        stage_t        res;
        logic [CFG_W:0] trial;
        logic          qbit;
        res = cur;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            trial = {res.rem, res.word[READING_W-1]};
            qbit  = (trial >= {1'b0, dmag});
            if (qbit) begin
                trial = trial - {1'b0, dmag};
            end
            res.rem  = trial[CFG_W-1:0];
            res.word = {res.word[READING_W-2:0], qbit};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/linear_range_map_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Stages from input item accept to m_tvalid: offset, multiply, magnitude,
// eight divider stages of four quotient bits each, output stage. Throughput:
// one item per cycle unless the output stalls; every stage hands on whenever
// the next one is empty or moving, so bubbles collapse and a stalled output
// holds in place. Reset (aresetn low, synchronous) empties the pipeline and
// sets the ranges to source 0..1 and target 0..1.
// ----------------------------------------------------------------------------
// Linear range map unit
// Maps a 32-bit reading from a configured input range onto a configured
// output range with a pipelined multiply and signed restoring division.
// ----------------------------------------------------------------------------
module linear_range_map_unit
    import lrm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // Input channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [READING_W-1:0] s_tdata,   // [31:0] reading
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [MAP_W-1:0]          m_tdata,   // [15:0] mapped
    output logic                      m_tuser    // [0] zero_span
);

    // Configuration registers.
    logic [CFG_W-1:0] source_low_reg;
    logic [CFG_W-1:0] source_high_reg;
    logic [CFG_W-1:0] target_low_reg;
    logic [CFG_W-1:0] target_high_reg;

    // Pipeline registers.
    stage_t              pipe_reg  [PIPE_STAGES];
    stage_t              pipe_next [PIPE_STAGES];
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES:0]   stg_rdy;

    // Output register.
    logic             out_vld_reg;
    logic [MAP_W-1:0] mapped_reg;
    logic [MAP_W-1:0] mapped_next;
    logic             zero_span_reg;

    // Derived range values; the user must change configuration only while the block is idle (not enforced here).
    logic [CFG_W-1:0]     span_in;
    logic [CFG_W-1:0]     span_out;
    logic [CFG_W-1:0]     div_mag;
    logic                 span_zero;
    logic [READING_W-1:0] low_ext;
    logic [READING_W-1:0] span_out_ext;
    logic [READING_W-1:0] prod_word;
    logic [MAP_W-1:0]     quot_low;

    assign span_in      = source_high_reg - source_low_reg;
    assign span_out     = target_high_reg - target_low_reg;
    assign span_zero    = (span_in == '0);
    assign div_mag      = span_in[CFG_W-1] ? (~span_in + 1'b1) : span_in;
    assign low_ext      = {{(READING_W-CFG_W){source_low_reg[CFG_W-1]}}, source_low_reg};
    assign span_out_ext = {{(READING_W-CFG_W){span_out[CFG_W-1]}}, span_out};

    // Ready chain: a stage may load when it is empty or its item moves on.
    always_comb begin
        stg_rdy[PIPE_STAGES] = !out_vld_reg || m_tready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
            stg_rdy[i] = !vld_reg[i] || stg_rdy[i+1];
        end
    end

    assign s_tready = stg_rdy[0];

    // Next payload of every stage, computed from the input or the stage before it.
    always_comb begin
        // Offset of the reading from the low end of the input range.
        pipe_next[STG_OFFSET].word = s_tdata - low_ext;
        pipe_next[STG_OFFSET].rem  = '0;
        pipe_next[STG_OFFSET].neg  = 1'b0;

        // Product wrapped to 32 bits.
        prod_word                   = pipe_reg[STG_OFFSET].word * span_out_ext;
        pipe_next[STG_PRODUCT].word = prod_word;
        pipe_next[STG_PRODUCT].rem  = '0;
        pipe_next[STG_PRODUCT].neg  = 1'b0;

        // Magnitude of the signed product and sign of the quotient.
        pipe_next[STG_MAGNITUDE].word = pipe_reg[STG_PRODUCT].word[READING_W-1]
                                      ? (~pipe_reg[STG_PRODUCT].word + 1'b1)
                                      : pipe_reg[STG_PRODUCT].word;
        pipe_next[STG_MAGNITUDE].rem  = '0;
        pipe_next[STG_MAGNITUDE].neg  = pipe_reg[STG_PRODUCT].word[READING_W-1]
                                      ^ span_in[CFG_W-1];

        // Divider stages.
        for (int s = 0; s < DIV_STAGES; s++) begin
            pipe_next[STG_DIV_FIRST+s] = div_stage(pipe_reg[STG_DIV_FIRST+s-1], div_mag);
        end
    end

    // Final sign, offset into the target range and zero span override.
    always_comb begin
        quot_low = pipe_reg[PIPE_STAGES-1].word[MAP_W-1:0];
        if (pipe_reg[PIPE_STAGES-1].neg) begin
            quot_low = ~quot_low + 1'b1;
        end
        mapped_next = span_zero ? '0 : (quot_low + target_low_reg);
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_low_reg  <= SOURCE_LOW_RST;
            source_high_reg <= SOURCE_HIGH_RST;
            target_low_reg  <= TARGET_LOW_RST;
            target_high_reg <= TARGET_HIGH_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SOURCE_LOW:  source_low_reg  <= cfg_wdata;
                REG_SOURCE_HIGH: source_high_reg <= cfg_wdata;
                REG_TARGET_LOW:  target_low_reg  <= cfg_wdata;
                REG_TARGET_HIGH: target_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (stg_rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                if (stg_rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (stg_rdy[PIPE_STAGES]) begin
                out_vld_reg <= vld_reg[PIPE_STAGES-1];
            end
        end
    end

    // Payload registers load alongside their valid bits.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < PIPE_STAGES; i++) begin
            if (stg_rdy[i]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
        if (stg_rdy[PIPE_STAGES]) begin
            mapped_reg    <= mapped_next;
            zero_span_reg <= span_zero;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = mapped_reg;
    assign m_tuser  = zero_span_reg;

endmodule
`default_nettype wire

// ===== test/lrm_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear range map checker
// Watches the configuration port and both stream channels of the linear range
// map unit. It keeps its own copy of the four range registers, works out the
// mapped value and zero-span flag for every accepted reading, and compares
// each accepted result item field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module lrm_map_checker
    import lrm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [READING_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [MAP_W-1:0]     m_tdata,
    input  wire logic                 m_tuser,
    output int                        mismatches,
    output int                        pending
);

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [MAP_W-1:0] mapped;
        logic             zero_span;
    } map_result_t;

    // Range registers as the block should hold them.
    logic [CFG_W-1:0] source_lo;
    logic [CFG_W-1:0] source_hi;
    logic [CFG_W-1:0] target_lo;
    logic [CFG_W-1:0] target_hi;

    // Results still owed by the block, oldest first.
    map_result_t expected_maps[$];

    // Scale one reading from the source range onto the target range. Every
    // step wraps at its own width; the division truncates toward zero.
    function automatic map_result_t scale_reading(input logic [READING_W-1:0] reading);
        map_result_t          res;
        logic [READING_W-1:0] offset;
        logic [READING_W-1:0] product;
        logic [CFG_W-1:0]     span_in;
        logic [CFG_W-1:0]     span_out;
        logic signed [63:0]   dividend;
        logic signed [63:0]   divisor;
        logic signed [63:0]   quotient;
        offset    = reading - {{(READING_W-CFG_W){source_lo[CFG_W-1]}}, source_lo};
        span_in   = source_hi - source_lo;
        span_out  = target_hi - target_lo;
        res.zero_span = (span_in == '0);
        if (res.zero_span) begin
            res.mapped = '0;
        end else begin
            product  = offset * {{(READING_W-CFG_W){span_out[CFG_W-1]}}, span_out};
            dividend = {{32{product[READING_W-1]}}, product};
            divisor  = {{(64-CFG_W){span_in[CFG_W-1]}}, span_in};
            // A dividend of -2^31 over -1 is fine here: 64-bit signed math.
            quotient   = dividend / divisor;
            res.mapped = quotient[MAP_W-1:0] + target_lo;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED) begin
            $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Compare results, then record new readings, then track register writes.
    always @(posedge aclk) begin
        map_result_t want;
        if (!aresetn) begin
            source_lo = SOURCE_LOW_RST;
            source_hi = SOURCE_HIGH_RST;
            target_lo = TARGET_LOW_RST;
            target_hi = TARGET_HIGH_RST;
            expected_maps.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_maps.size() == 0) begin
                    report_mismatch("result item with none expected",
                                    {{(32-MAP_W){1'b0}}, m_tdata}, {31'd0, m_tuser});
                end else begin
                    want = expected_maps.pop_front();
                    if (m_tdata !== want.mapped) begin
                        report_mismatch("mapped", {{(32-MAP_W){1'b0}}, m_tdata},
                                        {{(32-MAP_W){1'b0}}, want.mapped});
                    end
                    if (m_tuser !== want.zero_span) begin
                        report_mismatch("zero_span", {31'd0, m_tuser},
                                        {31'd0, want.zero_span});
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_maps.push_back(scale_reading(s_tdata));
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_SOURCE_LOW:  source_lo = cfg_wdata;
                    REG_SOURCE_HIGH: source_hi = cfg_wdata;
                    REG_TARGET_LOW:  target_lo = cfg_wdata;
                    REG_TARGET_HIGH: target_hi = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending = expected_maps.size();
    end

endmodule

// ===== test/linear_range_map_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear range map unit testbench
// Drives readings through the unit under a series of range settings: a short
// directed set covering the field extremes, zero input span, quotient overflow
// and reversed ranges, then random phases of mostly in-range readings. The
// sender works in bursts, the receiver stalls in changing patterns, and a
// separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module linear_range_map_unit_tb;
    import lrm_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 480;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [READING_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [MAP_W-1:0]     m_tdata;
    logic                 m_tuser;

    int map_errors;
    int maps_pending;

    // Reading accepted at the last rising edge.
    logic reading_taken = 1'b0;
    int   idle_cycles   = 0;

    // Sender burst state.
    int burst_left    = 0;
    bit steady_sender = 1'b0;

    // Receiver stall state.
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    // Current source range as signed values, used to aim readings.
    int src_lo = 0;
    int src_hi = 1;

    linear_range_map_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lrm_map_checker map_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (map_errors),
        .pending    (maps_pending)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        reading_taken <= s_tvalid && s_tready;
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: switches between always ready, coin flips, stall bursts and
    // mostly stalled.
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: begin
                if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
                    stall_left = $urandom_range(1, 30);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Random signed 16-bit value.
    function automatic int rand_cfg_value();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value[CFG_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_ranges(input int s_low, input int s_high,
                              input int t_low, input int t_high);
        write_reg(REG_SOURCE_LOW, s_low);
        write_reg(REG_SOURCE_HIGH, s_high);
        write_reg(REG_TARGET_LOW, t_low);
        write_reg(REG_TARGET_HIGH, t_high);
        src_lo = s_low;
        src_hi = s_high;
    endtask

    // Offer one reading and wait until it is taken; a new burst may open
    // with a gap.
    task automatic send_reading(input logic [READING_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (steady_sender) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(4, 16);
            end else begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = value;
        do begin
            @(posedge aclk);
            @(negedge aclk);
        end while (!reading_taken);
    endtask

    // Stop sending and let every owed result item come out.
    task automatic drain();
        s_tvalid = 1'b0;
        while (maps_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Pick new ranges: mostly ordinary increasing source ranges, some fully
    // random, some with zero span, some reversed.
    task automatic random_ranges();
        int kind;
        int s_low;
        int s_high;
        int t_low;
        int t_high;
        kind  = $urandom_range(0, 9);
        s_low = rand_cfg_value();
        t_low = rand_cfg_value();
        if ($urandom_range(0, 1) == 0) begin
            t_high = t_low + int'($urandom_range(0, 4000)) - 2000;
        end else begin
            t_high = rand_cfg_value();
        end
        if (kind <= 5) begin
            if ($urandom_range(0, 3) == 0) begin
                s_high = s_low + int'($urandom_range(1, 65535));
            end else begin
                s_high = s_low + int'($urandom_range(1, 2000));
            end
            if (s_high > 32767) begin
                s_high = 32767;
            end
        end else if (kind <= 7) begin
            s_high = rand_cfg_value();
        end else if (kind == 8) begin
            s_high = s_low;
        end else begin
            s_high = s_low - int'($urandom_range(1, 3000));
            if (s_high < -32768) begin
                s_high = -32768;
            end
        end
        set_ranges(s_low, s_high, t_low, t_high);
    endtask

    // Mostly readings inside the source range; the rest anywhere.
    function automatic logic [READING_W-1:0] pick_reading();
        int pick;
        int val;
        pick = $urandom_range(0, 9);
        if (pick < 7 && src_hi > src_lo) begin
            val = src_lo + int'($urandom_range(0, src_hi - src_lo));
            return val;
        end else if (pick == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        int sent;
        int count;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset ranges: source 0..1 onto target 0..1.
        send_reading(32'h0000_0000);
        send_reading(32'h0000_0001);
        send_reading(32'h0000_0002);
        send_reading(32'hFFFF_FFFF);
        send_reading(32'h8000_0000);
        drain();

        // Widest ranges; the input span wraps to minus one.
        set_ranges(-32768, 32767, -32768, 32767);
        send_reading(32'h0000_0000);
        send_reading(32'hFFFF_8000);
        send_reading(32'h0000_7FFF);
        send_reading(32'hFFFF_FFFF);
        drain();

        // Product of -2^31 over a span of minus one overflows the quotient.
        set_ranges(0, -1, 32767, -32768);
        send_reading(32'h8000_0000);
        send_reading(32'h7FFF_FFFF);
        drain();

        // Equal ends give a zero input span.
        set_ranges(5, 5, 100, 200);
        send_reading(32'h0000_0005);
        send_reading(32'hFFFF_FFFF);
        drain();

        // An ordinary ten-bit to eight-bit rescale.
        set_ranges(0, 1023, 0, 255);
        send_reading(32'h0000_0000);
        send_reading(32'h0000_0200);
        send_reading(32'h0000_03FF);
        send_reading(32'h0000_0400);
        drain();

        // Both ranges reversed.
        set_ranges(100, -100, 32767, -32768);
        send_reading(32'h0000_0000);
        send_reading(32'h0000_0064);
        send_reading(32'hFFFF_FF9C);
        drain();

        // Random phases, each under its own ranges.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_ranges();
            steady_sender = ($urandom_range(0, 3) == 0);
            count = $urandom_range(30, 80);
            repeat (count) send_reading(pick_reading());
            sent += count;
            drain();
        end

        if (map_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/lrm_pkg.sv
sv/linear_range_map_unit.sv
test/lrm_map_checker.sv
test/linear_range_map_unit_tb.sv
